>>> rtl/assert_macros.svh
// assertion macros used by the rtl top level
// assumes a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising clock edge outside reset
`define AZP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication form, antecedent and consequent given apart
`define AZP_ASSERT_IMPL(lbl, ante, cons, msg) \
	`AZP_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> rtl/azp_pkg.sv
// types, codes and constants of the angular z-buffer projector
// no dependencies
`timescale 1ns / 1ps

package azp_pkg;

	typedef enum logic [1:0] {
		OP_PROJECT,
		OP_READ,
		OP_CLEAR,
		OP_NONE
	} azp_op_t;

	typedef enum logic [2:0] {
		CFG_ROT_COS,
		CFG_ROT_SIN,
		CFG_TRANS_X,
		CFG_TRANS_Y,
		CFG_BINS_PER_RAD,
		CFG_ACTIVE_BINS,
		CFG_SPARE6,
		CFG_SPARE7
	} azp_cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROT,
		ST_SUM,
		ST_PRE,
		ST_ITER,
		ST_GAIN,
		ST_POS,
		ST_UPD,
		ST_RD,
		ST_RDOUT
	} azp_state_t;

	typedef struct packed {
		logic load;
		logic rot;
		logic sum;
		logic pre;
		logic iter;
		logic gain;
		logic pos;
		logic upd;
		logic rd;
		logic clr;
		logic cnt_zero;
		logic out_load;
	} azp_cmd_t;

	typedef struct packed {
		logic iter_last;
		logic clr_last;
	} azp_sts_t;

	localparam logic signed [15:0] ROT_COS_RST = 16'sd16384;
	localparam logic [23:0] BPR_RST = 24'd890043;
	localparam logic [10:0] ACTIVE_RST = 11'd1024;
	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic [15:0] GAIN_Q16 = 16'd39797;
	localparam logic [15:0] EMPTY_RANGE = 16'hFFFF;

	// arctan(2^-i) in Q.16 radians
	function automatic logic [15:0] atan_q16(input logic [4:0] i);
		logic [15:0] v;
		case (i)
			5'd0: v = 16'd51472;
			5'd1: v = 16'd30386;
			5'd2: v = 16'd16055;
			5'd3: v = 16'd8150;
			5'd4: v = 16'd4091;
			5'd5: v = 16'd2047;
			5'd6: v = 16'd1024;
			5'd7: v = 16'd512;
			5'd8: v = 16'd256;
			5'd9: v = 16'd128;
			5'd10: v = 16'd64;
			5'd11: v = 16'd32;
			5'd12: v = 16'd16;
			5'd13: v = 16'd8;
			5'd14: v = 16'd4;
			5'd15: v = 16'd2;
			5'd16: v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/azp_ctrl.sv
// sequencer of the projector: item intake, step order, result valid
// depends on azp_pkg
`timescale 1ns / 1ps

module azp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        op,
	output logic              m_tvalid,
	input  logic              m_tready,
	output azp_pkg::azp_cmd_t cmd,
	input  azp_pkg::azp_sts_t sts
);

	azp_pkg::azp_state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= azp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			azp_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					cmd.cnt_zero = 1'b1;
					state_d = azp_pkg::ST_IDLE;
				end
			end
			azp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					case (azp_pkg::azp_op_t'(op))
						azp_pkg::OP_PROJECT: state_d = azp_pkg::ST_ROT;
						azp_pkg::OP_READ: state_d = azp_pkg::ST_RD;
						azp_pkg::OP_CLEAR: state_d = azp_pkg::ST_CLEAR;
						default: state_d = azp_pkg::ST_IDLE;
					endcase
				end
			end
			azp_pkg::ST_ROT: begin
				cmd.rot = 1'b1;
				state_d = azp_pkg::ST_SUM;
			end
			azp_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = azp_pkg::ST_PRE;
			end
			azp_pkg::ST_PRE: begin
				cmd.pre = 1'b1;
				cmd.cnt_zero = 1'b1;
				state_d = azp_pkg::ST_ITER;
			end
			azp_pkg::ST_ITER: begin
				cmd.iter = 1'b1;
				if (sts.iter_last) begin
					cmd.cnt_zero = 1'b1;
					state_d = azp_pkg::ST_GAIN;
				end
			end
			azp_pkg::ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d = azp_pkg::ST_POS;
			end
			azp_pkg::ST_POS: begin
				cmd.pos = 1'b1;
				state_d = azp_pkg::ST_UPD;
			end
			azp_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = azp_pkg::ST_IDLE;
			end
			azp_pkg::ST_RD: begin
				cmd.rd = 1'b1;
				state_d = azp_pkg::ST_RDOUT;
			end
			azp_pkg::ST_RDOUT: begin
				// wait until the output register is free
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d = azp_pkg::ST_IDLE;
				end
			end
			default: state_d = azp_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> rtl/azp_datapath.sv
// datapath of the projector: config registers, pose rotation, cordic,
// bin mapping, bin store and result register; depends on azp_pkg
`timescale 1ns / 1ps

module azp_datapath #(
	parameter int NUM_BINS = 1024,
	parameter int CORDIC_STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [95:0]       s_tdata,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [2:0]        cfg_addr,
	input  logic [23:0]       cfg_data,
	input  azp_pkg::azp_cmd_t cmd,
	output azp_pkg::azp_sts_t sts,
	output logic [39:0]       m_tdata
);

	localparam int BW = $clog2(NUM_BINS);
	localparam int CNTW = $clog2((NUM_BINS > 32) ? NUM_BINS : 32);
	localparam logic signed [45:0] NEG_LIM = -46'sd268435456;

	// configuration
	logic signed [15:0] rot_cos_q, rot_sin_q, trans_x_q, trans_y_q;
	logic [23:0] bpr_q;
	logic [10:0] active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_cos_q <= azp_pkg::ROT_COS_RST;
			rot_sin_q <= '0;
			trans_x_q <= '0;
			trans_y_q <= '0;
			bpr_q <= azp_pkg::BPR_RST;
			active_q <= azp_pkg::ACTIVE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (azp_pkg::azp_cfg_t'(cfg_addr))
				azp_pkg::CFG_ROT_COS: rot_cos_q <= cfg_data[15:0];
				azp_pkg::CFG_ROT_SIN: rot_sin_q <= cfg_data[15:0];
				azp_pkg::CFG_TRANS_X: trans_x_q <= cfg_data[15:0];
				azp_pkg::CFG_TRANS_Y: trans_y_q <= cfg_data[15:0];
				azp_pkg::CFG_BINS_PER_RAD: bpr_q <= cfg_data;
				azp_pkg::CFG_ACTIVE_BINS: active_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// step counter, shared by the cordic and the clearing sweep
	logic [CNTW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_zero) begin
			cnt_q <= '0;
		end else if (cmd.iter || cmd.clr) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign sts.iter_last = (cnt_q == CNTW'(CORDIC_STEPS - 1));
	assign sts.clr_last = (cnt_q == CNTW'(NUM_BINS - 1));

	// latched item
	logic signed [15:0] x_q, y_q, nx_q, ny_q;
	logic [15:0] id_q;
	logic [BW-1:0] sel_addr_q;
	logic sel_ok_q;
	logic [12:0] sel_w;

	assign sel_w = 13'(s_tdata[89:80]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= s_tdata[15:0];
			y_q <= s_tdata[31:16];
			nx_q <= s_tdata[47:32];
			ny_q <= s_tdata[63:48];
			id_q <= s_tdata[79:64];
			sel_addr_q <= sel_w[BW-1:0];
			sel_ok_q <= (sel_w < 13'(NUM_BINS));
		end
	end

	// rotation products
	logic signed [31:0] p_cx_q, p_sy_q, p_sx_q, p_cy_q;
	logic signed [31:0] n_cx_q, n_sy_q, n_sx_q, n_cy_q;

	always_ff @(posedge clk) begin
		if (cmd.rot) begin
			p_cx_q <= rot_cos_q * x_q;
			p_sy_q <= rot_sin_q * y_q;
			p_sx_q <= rot_sin_q * x_q;
			p_cy_q <= rot_cos_q * y_q;
			n_cx_q <= rot_cos_q * nx_q;
			n_sy_q <= rot_sin_q * ny_q;
			n_sx_q <= rot_sin_q * nx_q;
			n_cy_q <= rot_cos_q * ny_q;
		end
	end

	// rounded sums, translated point and exact rotated normal
	logic signed [33:0] sum_x, sum_y;
	logic signed [20:0] px_q, py_q;
	logic signed [32:0] rnx_q, rny_q;

	assign sum_x = 34'(p_cx_q) - 34'(p_sy_q) + 34'sd8192;
	assign sum_y = 34'(p_sx_q) + 34'(p_cy_q) + 34'sd8192;

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			px_q <= 21'(sum_x >>> 14) + 21'(trans_x_q);
			py_q <= 21'(sum_y >>> 14) + 21'(trans_y_q);
			rnx_q <= 33'(n_cx_q) - 33'(n_sy_q);
			rny_q <= 33'(n_sx_q) + 33'(n_cy_q);
		end
	end

	// cordic vectoring
	logic signed [30:0] xs, ys, cx_q, y_q2, dx, dy;
	logic signed [19:0] z_q, at;
	logic orig_q;
	logic [4:0] sh;

	assign xs = 31'(px_q) <<< 8;
	assign ys = 31'(py_q) <<< 8;
	assign sh = cnt_q[4:0];
	assign dx = y_q2 >>> sh;
	assign dy = cx_q >>> sh;
	assign at = $signed(20'(azp_pkg::atan_q16(sh)));

	// facing test: dot product in four partial products, one per early step
	logic signed [20:0] mul_a;
	logic signed [32:0] rn_sel;
	logic signed [17:0] mul_b;
	logic signed [38:0] mprod;
	logic signed [55:0] addend, acc_q;

	assign mul_a = cnt_q[1] ? py_q : px_q;
	assign rn_sel = cnt_q[1] ? rny_q : rnx_q;
	assign mul_b = cnt_q[0] ? 18'($signed(rn_sel[32:17])) : $signed({1'b0, rn_sel[16:0]});
	assign mprod = 39'(mul_a) * 39'(mul_b);
	assign addend = cnt_q[0] ? (56'(mprod) <<< 17) : 56'(mprod);

	always_ff @(posedge clk) begin
		if (cmd.pre) begin
			acc_q <= '0;
			orig_q <= (px_q == '0) && (py_q == '0);
			if (xs < 0) begin
				if (ys >= 0) begin
					cx_q <= ys;
					y_q2 <= -xs;
					z_q <= azp_pkg::HALF_PI_Q16;
				end else begin
					cx_q <= -ys;
					y_q2 <= xs;
					z_q <= -azp_pkg::HALF_PI_Q16;
				end
			end else begin
				cx_q <= xs;
				y_q2 <= ys;
				z_q <= '0;
			end
		end else if (cmd.iter) begin
			if (cnt_q < CNTW'(4)) begin
				acc_q <= acc_q + addend;
			end
			if (y_q2 > 0) begin
				cx_q <= cx_q + dx;
				y_q2 <= y_q2 - dy;
				z_q <= z_q + at;
			end else begin
				cx_q <= cx_q - dx;
				y_q2 <= y_q2 + dy;
				z_q <= z_q - at;
			end
		end
	end

	// gain and bin scaling products
	logic [29:0] xc;
	logic signed [19:0] zz;
	logic [45:0] gprod_q;
	logic signed [44:0] aprod_q;

	assign xc = (orig_q || cx_q[30]) ? 30'd0 : cx_q[29:0];
	assign zz = orig_q ? 20'sd0 : z_q;

	always_ff @(posedge clk) begin
		if (cmd.gain) begin
			gprod_q <= 46'(xc) * 46'(azp_pkg::GAIN_Q16);
			aprod_q <= 45'(zz) * $signed({21'd0, bpr_q});
		end
	end

	// range rounding, bin position and store lookup
	logic [45:0] rsum;
	logic [21:0] rr;
	logic [15:0] rng;
	logic signed [45:0] pos;
	logic [17:0] bin_hi;
	logic [12:0] lim;
	logic pos_ok;
	logic [BW-1:0] pos_addr, bin_q;
	logic bin_ok_q;
	logic [15:0] range_q;
	logic [16:0] owner_q;

	assign rsum = gprod_q + 46'd8388608;
	assign rr = rsum[45:24];
	assign rng = (|rr[21:16]) ? azp_pkg::EMPTY_RANGE : rr[15:0];
	assign pos = 46'(aprod_q) + $signed({8'd0, active_q, 27'd0});
	assign bin_hi = pos[45:28];
	assign lim = (13'(active_q) < 13'(NUM_BINS)) ? 13'(active_q) : 13'(NUM_BINS);
	// negative positions above minus one bin truncate to bin zero
	assign pos_ok = pos[45] ? ((pos > NEG_LIM) && (lim != '0)) : (bin_hi < 18'(lim));
	assign pos_addr = pos[45] ? '0 : bin_hi[BW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.pos) begin
			bin_q <= pos_addr;
			bin_ok_q <= pos_ok;
			range_q <= rng;
			owner_q <= (acc_q <= 0) ? {1'b0, id_q} : '1;
		end
	end

	// bin store: filled flag, range, owner
	logic [33:0] mem_q [NUM_BINS];
	logic [33:0] rdata_q, wdata;
	logic mem_we, mem_re;
	logic [BW-1:0] waddr, raddr;
	logic rd_filled;
	logic [15:0] rd_range;
	logic [16:0] rd_owner;

	assign rd_filled = rdata_q[33];
	assign rd_range = rdata_q[32:17];
	assign rd_owner = rdata_q[16:0];

	assign mem_re = cmd.pos || cmd.rd;
	assign raddr = cmd.rd ? sel_addr_q : pos_addr;
	assign mem_we = cmd.clr || (cmd.upd && bin_ok_q && (!rd_filled || (range_q < rd_range)));
	assign waddr = cmd.clr ? cnt_q[BW-1:0] : bin_q;
	assign wdata = cmd.clr ? 34'd0 : {1'b1, range_q, owner_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// result register
	logic [15:0] out_range_q;
	logic [16:0] out_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_range_q <= (sel_ok_q && rd_filled) ? rd_range : azp_pkg::EMPTY_RANGE;
			out_idx_q <= (sel_ok_q && rd_filled) ? rd_owner : '1;
		end
	end

	assign m_tdata = {7'd0, out_idx_q, out_range_q};

endmodule

>>> rtl/angular_zbuffer_projector_core.sv
// channel     dir  handshake                   payload
// s_*         in   s_tvalid / s_tready         s_tdata item fields, s_tuser op
// m_*         out  m_tvalid / m_tready         m_tdata range and point index
// cfg_*       in   cfg_valid / cfg_ready       cfg_addr register, cfg_data value
// a project item steps through rot, sum, pre, iter, gain, pos and upd before the
// next intake, the cordic iterating one step per cycle; a read passes rd and rdout,
// waiting for the output register to be free, and a clear sweeps every bin
// after reset the bin store is swept with s_tready low
// config writes are taken every cycle; a pending result does not block intake
// top level of the projector; depends on azp_pkg, azp_ctrl, azp_datapath and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module angular_zbuffer_projector_core #(
	parameter int NUM_BINS = 1024,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // point_x, point_y, normal_x, normal_y, point_id, bin_sel
	input  logic [1:0]  s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // range, point_index
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_data
);

	azp_pkg::azp_cmd_t cmd;
	azp_pkg::azp_sts_t sts;

	assign cfg_ready = 1'b1;

	azp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	azp_datapath #(
		.NUM_BINS     (NUM_BINS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata)
	);

	`AZP_ASSERT_IMPL(a_out_no_overwrite, cmd.out_load, !m_tvalid || m_tready, "result overwritten")
	`AZP_ASSERT(a_out_shown, cmd.out_load |=> m_tvalid, "loaded result not shown")
	`AZP_ASSERT_IMPL(a_no_intake_in_sweep, cmd.clr, !s_tready, "intake during clearing sweep")
	`AZP_ASSERT(a_one_step, $onehot0({cmd.rot, cmd.sum, cmd.pre, cmd.iter, cmd.gain, cmd.pos, cmd.upd, cmd.clr}), "steps overlap")

endmodule
